// ----- hdl/swmcd_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the match-count stack.
`timescale 1ns / 1ps
package swmcd_pkg;

	// Storage geometry
	localparam int DEPTH      = 16;
	localparam int ITEM_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Request field widths
	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;

	// Result field widths
	localparam int HEAD_W   = 32;
	localparam int STATUS_W = 2;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_PEEK   = 3'd1,
		OP_POP    = 3'd2,
		OP_COUNT  = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic scan_start;
		logic scan_step;
		logic scan_finish;
		logic publish;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic op_is_scan;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- hdl/stack_with_match_count_delete.sv -----
// Top level of the match-count stack: controller, datapath and stream port packing.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser = op, s_tdata = value
//  m_*      out  m_tvalid/m_tready  m_tdata = head_item, match_count, entries, is_empty, status
//
// One request at a time. Push, peek and pop go from accept through the execute state to the done state.
// Count and delete walk the stored entries through the single memory read port,
// one entry per cycle.
// A new request is accepted while the previous result still waits in the output register.
// Reset clears the entry count; the entry memory needs no clearing.
`timescale 1ns / 1ps
module stack_with_match_count_delete (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [2:0]  s_tuser,   // [2:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [31:0] head_item, [36:32] match_count,
	                               // [41:37] entries, [42] is_empty, [44:43] status, [47:45] zero
);
	import swmcd_pkg::*;

	dp_cmd_t              cmd;
	dp_stat_t             st;
	logic [HEAD_W-1:0]    head_item;
	logic [CNT_W-1:0]     match_count;
	logic [CNT_W-1:0]     entries;
	logic                 is_empty;
	logic [STATUS_W-1:0]  status;

	swmcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	swmcd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (s_tuser),
		.value       (s_tdata),
		.cmd         (cmd),
		.st          (st),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.head_item   (head_item),
		.match_count (match_count),
		.entries     (entries),
		.is_empty    (is_empty),
		.status      (status)
	);

	// Result packing, lowest field first
	assign m_tdata = {3'b000, status, is_empty, entries, match_count, head_item};

endmodule

// ----- hdl/swmcd_ctrl.sv -----
// Controller state machine: sequences accept, execute, list walk and result hand-off.
`timescale 1ns / 1ps
module swmcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  swmcd_pkg::dp_stat_t st,
	output swmcd_pkg::dp_cmd_t  cmd
);
	import swmcd_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.op_is_scan) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_SCAN: begin
				if (st.scan_done) begin
					cmd.scan_finish = 1'b1;
					state_d         = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_DONE: begin
				// wait for the output register to free up
				if (st.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Checks
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> st.out_free)
		else $error("result published while output register busy");

	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_EXEC))
		else $error("accepted transaction not executed next cycle");

endmodule

// ----- hdl/swmcd_dp.sv -----
// Datapath: entry memory, count, walk pointers, match counter and output register.
`timescale 1ns / 1ps
module swmcd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [swmcd_pkg::OP_W-1:0]        op,
	input  logic [swmcd_pkg::VALUE_W-1:0]     value,
	input  swmcd_pkg::dp_cmd_t                cmd,
	output swmcd_pkg::dp_stat_t               st,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [swmcd_pkg::HEAD_W-1:0]      head_item,
	output logic [swmcd_pkg::CNT_W-1:0]       match_count,
	output logic [swmcd_pkg::CNT_W-1:0]       entries,
	output logic                              is_empty,
	output logic [swmcd_pkg::STATUS_W-1:0]    status
);
	import swmcd_pkg::*;

	// Entry memory, one write and one registered read port
	logic [ITEM_WIDTH-1:0] mem [DEPTH];
	logic [ITEM_WIDTH-1:0] rd_data_q;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [ITEM_WIDTH-1:0] wr_data;

	// Request and list state
	logic [OP_W-1:0]       op_q;
	logic [ITEM_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      kept_q;
	logic [CNT_W-1:0]      match_q;
	logic                  vld_s1;
	logic [HEAD_W-1:0]     head_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  out_valid_q;

	logic                  full;
	logic                  hit;
	logic                  is_delete;

	assign full      = (count_q >= CNT_W'(DEPTH));
	assign is_delete = (op_q == OP_DELETE);
	assign hit       = vld_s1 && (rd_data_q == val_q);

	// Read the walk pointer while scanning, the head slot otherwise
	assign rd_addr = cmd.scan_step ? idx_q[IDX_W-1:0] : IDX_W'(count_q - CNT_W'(1));

	// Write port: push at the top, or compaction during delete
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = val_q;
		if (cmd.exec && (op_q == OP_PUSH) && !full) begin
			wr_en = 1'b1;
		end else if (cmd.scan_step && vld_s1 && is_delete && !hit) begin
			wr_en   = 1'b1;
			wr_addr = kept_q[IDX_W-1:0];
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			val_q <= value[ITEM_WIDTH-1:0];
		end
	end

	// List state, walk and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			kept_q   <= '0;
			match_q  <= '0;
			vld_s1   <= 1'b0;
			head_q   <= '0;
			status_q <= ST_OK;
		end else begin
			if (cmd.exec) begin
				match_q <= '0;
				case (op_q)
					OP_PUSH: begin
						head_q <= '0;
						if (full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_OK;
							count_q  <= count_q + CNT_W'(1);
						end
					end
					OP_PEEK: begin
						if (count_q == '0) begin
							head_q   <= '0;
							status_q <= ST_EMPTY;
						end else begin
							head_q   <= HEAD_W'(rd_data_q);
							status_q <= ST_OK;
						end
					end
					OP_POP: begin
						head_q <= '0;
						if (count_q == '0) begin
							status_q <= ST_EMPTY;
						end else begin
							status_q <= ST_OK;
							count_q  <= count_q - CNT_W'(1);
						end
					end
					default: begin
						head_q   <= '0;
						status_q <= ST_OK;
					end
				endcase
			end
			if (cmd.scan_start) begin
				idx_q   <= '0;
				kept_q  <= '0;
				match_q <= '0;
				vld_s1  <= 1'b0;
			end
			if (cmd.scan_step) begin
				// issue the next read
				if (idx_q < count_q) begin
					idx_q  <= idx_q + CNT_W'(1);
					vld_s1 <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
				// judge the entry read last cycle
				if (vld_s1) begin
					if (hit) begin
						match_q <= match_q + CNT_W'(1);
					end else if (is_delete) begin
						kept_q <= kept_q + CNT_W'(1);
					end
				end
			end
			if (cmd.scan_finish) begin
				head_q   <= '0;
				status_q <= ST_OK;
				if (is_delete) begin
					count_q <= kept_q;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			head_item   <= head_q;
			match_count <= match_q;
			entries     <= count_q;
			is_empty    <= (count_q == '0);
			status      <= status_q;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign st.op_is_scan = (op_q == OP_COUNT) || (op_q == OP_DELETE);
	assign st.scan_done  = (idx_q == count_q) && !vld_s1;
	assign st.out_free   = !out_valid_q || m_tready;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_walk_balance: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, kept_q} + {1'b0, match_q}) <= {1'b0, idx_q})
		else $error("kept plus matched exceeds entries walked");

	a_pipe_index: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (idx_q != '0))
		else $error("read in flight without a walked entry");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && vld_s1) |-> (kept_q < idx_q))
		else $error("compaction write would pass the read pointer");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the bounded stack with match count and delete.
`timescale 1ns / 1ps
module testbench;
	import swmcd_pkg::*;

	// Run shape
	localparam int RANDOM_ITEMS   = 1600;
	localparam int POOL_SIZE      = 5;
	localparam int PRESSURE_POINT = 500;
	localparam int PRESSURE_HOLD  = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int IDLE_LIMIT     = 2000;

	// Op codes the block has no meaning for
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	// One expected response
	typedef struct {
		logic [HEAD_W-1:0] head;
		logic [CNT_W-1:0]  match_cnt;
		logic [CNT_W-1:0]  entries;
		logic              empty;
		status_t           status;
	} stack_result_t;

	// Shadow copy of the stack and the queue of responses it predicts
	class stack_shadow;
		logic [ITEM_WIDTH-1:0] slots [DEPTH];
		int unsigned           fill = 0;
		stack_result_t         pending[$];
		int unsigned           errors = 0;
		int unsigned           requests = 0;
		int unsigned           checked = 0;
		int unsigned           full_rejects = 0;
		int unsigned           empty_hits = 0;
		int unsigned           removed = 0;

		// Apply an accepted request and queue the response it must produce
		function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
			stack_result_t r;
			int unsigned   kept;
			r.head      = '0;
			r.match_cnt = '0;
			r.status    = ST_OK;
			requests++;
			case (op)
				OP_PUSH: begin
					if (fill >= DEPTH) begin
						r.status = ST_FULL;
						full_rejects++;
					end else begin
						slots[fill] = value;
						fill++;
					end
				end
				OP_PEEK: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
						empty_hits++;
					end else
						r.head = slots[fill-1];
				end
				OP_POP: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
						empty_hits++;
					end else
						fill--;
				end
				OP_COUNT: begin
					for (int i = 0; i < fill; i++)
						if (slots[i] == value)
							r.match_cnt++;
				end
				OP_DELETE: begin
					// compact survivors toward the bottom, order kept
					kept = 0;
					for (int i = 0; i < fill; i++) begin
						if (slots[i] == value)
							r.match_cnt++;
						else begin
							slots[kept] = slots[i];
							kept++;
						end
					end
					fill = kept;
					removed += r.match_cnt;
				end
				default: ;
			endcase
			r.entries = fill[CNT_W-1:0];
			r.empty   = (fill == 0);
			pending.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		// Check one response beat against the oldest prediction
		function void check_result(logic [47:0] beat);
			stack_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response, actual %0h", $time, beat);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			compare("head_item", want.head, beat[31:0]);
			compare("match_count", 32'(want.match_cnt), 32'(beat[36:32]));
			compare("entries", 32'(want.entries), 32'(beat[41:37]));
			compare("is_empty", 32'(want.empty), 32'(beat[42]));
			compare("status", 32'(want.status), 32'(beat[44:43]));
			compare("padding", 32'd0, 32'(beat[47:45]));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic [2:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [47:0]          m_tdata;

	stack_shadow          stack = new;
	bit                   steady = 0;
	bit                   pressure_done = 0;
	logic [VALUE_W-1:0]   pool [POOL_SIZE];

	stack_with_match_count_delete i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one request after a random gap, or none in steady phases, and wait for the transaction
	task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser  <= op;
		s_tdata  <= value;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		stack.note_request(op, value);
	endtask

	// Value for push, count or delete: mostly from a small pool so matches occur
	function automatic logic [VALUE_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 8)
			return pool[$urandom_range(0, POOL_SIZE-1)];
		return $urandom();
	endfunction

	// Random op, biased toward filling or draining the stack
	function automatic logic [OP_W-1:0] pick_op(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if (filling) begin
			if (r < 58) return OP_PUSH;
			if (r < 68) return OP_PEEK;
			if (r < 76) return OP_POP;
			if (r < 88) return OP_COUNT;
			return OP_DELETE;
		end
		if (r < 18) return OP_PUSH;
		if (r < 28) return OP_PEEK;
		if (r < 60) return OP_POP;
		if (r < 75) return OP_COUNT;
		return OP_DELETE;
	endfunction

	// Response side: random backpressure plus one long hold-off
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = steady ? 0 : $urandom_range(0, 4);
			if (!pressure_done && stack.checked >= PRESSURE_POINT) begin
				wait_cycles   = PRESSURE_HOLD;
				pressure_done = 1;
			end
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			stack.check_result(m_tdata);
		end
	end

	// Watchdog: give up after a long run of cycles with no transaction
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("[stack_with_match_count_delete] ERROR");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		pool[0]  = '0;
		pool[1]  = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			pool[i] = $urandom();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every op but push on an empty stack, including the spare op codes
		send_request(OP_PEEK, '1);
		send_request(OP_POP, '0);
		send_request(OP_COUNT, '0);
		send_request(OP_DELETE, '1);
		send_request(OP_SPARE_LO, '1);
		send_request(OP_SPARE_HI, '0);

		// Fill with the extreme values, then push once more into a full stack
		for (int i = 0; i < DEPTH; i++)
			send_request(OP_PUSH, (i % 2) ? {VALUE_W{1'b1}} : {VALUE_W{1'b0}});
		send_request(OP_PUSH, 32'h5A5A_A5A5);
		send_request(OP_COUNT, '1);
		send_request(OP_DELETE, '0);
		send_request(OP_PEEK, 32'h1234_5678);

		// Random traffic in alternating fill and drain phases
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			logic [OP_W-1:0] op;
			steady = ((n / 100) % 5 == 3);
			op = pick_op(((n / 48) % 2) == 0);
			if (op == OP_PUSH || op == OP_COUNT || op == OP_DELETE)
				send_request(op, pick_value());
			else
				send_request(op, $urandom());
		end
		s_tvalid <= 1'b0;
		steady = 0;

		// Let the last responses drain
		while (stack.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (stack.pending.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, stack.pending.size());
			stack.errors++;
		end

		$display("Ran %0d requests and checked %0d responses, %0d mismatches.",
			stack.requests, stack.checked, stack.errors);
		$display("Rejected full pushes: %0d, empty peeks/pops: %0d, entries deleted: %0d.",
			stack.full_rejects, stack.empty_hits, stack.removed);
		if (stack.errors == 0)
			$display("[stack_with_match_count_delete] OK");
		else
			$display("[stack_with_match_count_delete] ERROR");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/swmcd_pkg.sv
hdl/swmcd_ctrl.sv
hdl/swmcd_dp.sv
hdl/stack_with_match_count_delete.sv
bench/testbench.sv
